// ===== rtl/core/ebbpa_pkg.sv =====
`default_nettype none
package ebbpa_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int POS_BITS       = 32;
    localparam int DUTY_BITS      = 7;
    localparam int BAND_BITS      = 16;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX        = 7'd100;
    localparam logic [DUTY_BITS-1:0] DRIVE_DUTY_RST  = 7'd70;
    localparam logic [BAND_BITS-1:0] DEAD_BAND_RST   = 16'd16;
    localparam logic [POS_BITS-1:0]  TARGET_MIN_RST  = 32'h8000_0000;
    localparam logic [POS_BITS-1:0]  TARGET_MAX_RST  = 32'h7FFF_FFFF;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_BITS-1:0] REG_DRIVE_DUTY    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DEAD_BAND     = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_MIN    = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_MAX    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MOTION_ENABLE = 3'd4;

    typedef enum logic [1:0] {
        ACT_ENC_SAMPLE = 2'd0,
        ACT_CTRL_TICK  = 2'd1,
        ACT_MOVE_ABS   = 2'd2,
        ACT_MOVE_REL   = 2'd3
    } action_t;

    typedef struct packed {
        action_t               action;
        logic                  quad_a;
        logic                  quad_b;
        logic [POS_BITS-1:0]   target;
    } item_t;

    typedef struct packed {
        logic [DUTY_BITS-1:0]  drive_duty;
        logic [BAND_BITS-1:0]  dead_band;
        logic [POS_BITS-1:0]   target_min;
        logic [POS_BITS-1:0]   target_max;
        logic                  motion_enable;
    } cfg_t;

    typedef struct packed {
        logic                  bridge_high;
        logic                  bridge_low;
        logic [DUTY_BITS-1:0]  pwm_duty;
        logic [POS_BITS-1:0]   position;
        logic [POS_BITS-1:0]   setpoint;
    } result_t;

    // quadrature step from the 4-bit history {prev b, prev a, b, a}
    function automatic logic signed [1:0] quad_step(input logic [3:0] hist);
        logic signed [1:0] step;
        case (hist)
            4'd1, 4'd7, 4'd8, 4'd14: step = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
            default: step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ebbpa_core.sv =====
`default_nettype none
module ebbpa_core
    import ebbpa_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic step_en,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result
);

    localparam int ERR_BITS = ((COUNT_BITS > POS_BITS) ? COUNT_BITS : POS_BITS) + 2;
    localparam int WIDE_BITS = (COUNT_BITS > 64) ? COUNT_BITS : 64;

    logic [3:0]             hist_reg, hist_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic signed [POS_BITS-1:0] goal_reg, goal_next;
    logic                   rev_reg, rev_next;
    logic                   line_one_reg, line_one_next;
    logic                   line_two_reg, line_two_next;
    logic [DUTY_BITS-1:0]   duty_reg, duty_next;

    logic signed [ERR_BITS-1:0] err, band;
    logic signed [POS_BITS:0]   goal_cand;
    logic [DUTY_BITS-1:0]       duty_sat;
    logic [WIDE_BITS-1:0]       count_wide;

    assign err  = ERR_BITS'(goal_reg) - ERR_BITS'($signed(count_reg));
    assign band = ERR_BITS'($signed({1'b0, cfg.dead_band}));
    assign duty_sat = (cfg.drive_duty > DUTY_MAX) ? DUTY_MAX : cfg.drive_duty;

    // relative moves are summed one bit wider so the clamp sees the true value
    assign goal_cand = (item.action == ACT_MOVE_REL)
                     ? (POS_BITS+1)'(goal_reg) + (POS_BITS+1)'($signed(item.target))
                     : (POS_BITS+1)'($signed(item.target));

    always_comb begin
        hist_next     = hist_reg;
        count_next    = count_reg;
        goal_next     = goal_reg;
        rev_next      = rev_reg;
        line_one_next = line_one_reg;
        line_two_next = line_two_reg;
        duty_next     = duty_reg;
        case (item.action)
            ACT_ENC_SAMPLE: begin
                hist_next  = {hist_reg[1:0], item.quad_b, item.quad_a};
                count_next = count_reg + COUNT_BITS'(quad_step(hist_next));
            end
            ACT_CTRL_TICK: begin
                if (cfg.motion_enable) begin
                    if (err > band) begin
                        if (rev_reg) begin
                            rev_next      = 1'b0;
                            line_one_next = 1'b0;
                            line_two_next = 1'b0;
                        end else begin
                            line_one_next = 1'b0;
                            line_two_next = 1'b1;
                            duty_next     = duty_sat;
                        end
                    end else if (err < -band) begin
                        if (!rev_reg) begin
                            rev_next      = 1'b1;
                            line_one_next = 1'b0;
                            line_two_next = 1'b0;
                        end else begin
                            line_one_next = 1'b1;
                            line_two_next = 1'b0;
                            duty_next     = duty_sat;
                        end
                    end else begin
                        line_one_next = 1'b0;
                        line_two_next = 1'b0;
                        duty_next     = '0;
                    end
                end
            end
            ACT_MOVE_ABS, ACT_MOVE_REL: begin
                if (goal_cand > (POS_BITS+1)'($signed(cfg.target_max))) begin
                    goal_next = $signed(cfg.target_max);
                end else if (goal_cand < (POS_BITS+1)'($signed(cfg.target_min))) begin
                    goal_next = $signed(cfg.target_min);
                end else begin
                    goal_next = goal_cand[POS_BITS-1:0];
                end
            end
            default: begin
                hist_next = hist_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg     <= '0;
            count_reg    <= '0;
            goal_reg     <= '0;
            rev_reg      <= 1'b0;
            line_one_reg <= 1'b0;
            line_two_reg <= 1'b0;
            duty_reg     <= '0;
        end else if (step_en) begin
            hist_reg     <= hist_next;
            count_reg    <= count_next;
            goal_reg     <= goal_next;
            rev_reg      <= rev_next;
            line_one_reg <= line_one_next;
            line_two_reg <= line_two_next;
            duty_reg     <= duty_next;
        end
    end

    // narrow counts show zero-extended
    assign count_wide = WIDE_BITS'(count_next);

    assign result.bridge_high = line_one_next;
    assign result.bridge_low  = line_two_next;
    assign result.pwm_duty    = duty_next;
    assign result.position    = count_wide[POS_BITS-1:0];
    assign result.setpoint    = goal_next;

endmodule
`default_nettype wire

// ===== rtl/core/encoder_bang_bang_position_axis.sv =====
// path: an accepted request is held in the input register, and its result is then written to the result register
// throughput: one request per cycle while the result slot is free or being taken, set by the single state-update stage
// that reads the axis state and writes it back with the result register
// reset: synchronous active-low aresetn clears position, setpoint, history,
// direction, bridge lines and duty, and loads the register defaults
`default_nettype none
module encoder_bang_bang_position_axis
    import ebbpa_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     cfg_wr_en,
    input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_wr_data,

    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [39:0]              s_tdata,   // quad_a, quad_b, target[31:0], pad
    input  wire logic [1:0]               s_tuser,   // action

    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [79:0]                   m_tdata    // bridge_high, bridge_low, pwm_duty[6:0],
                                                     // position[31:0], setpoint[31:0], pad
);

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t result;
    logic    advance;
    logic    s_accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.drive_duty    <= DRIVE_DUTY_RST;
            cfg_reg.dead_band     <= DEAD_BAND_RST;
            cfg_reg.target_min    <= TARGET_MIN_RST;
            cfg_reg.target_max    <= TARGET_MAX_RST;
            cfg_reg.motion_enable <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DRIVE_DUTY:    cfg_reg.drive_duty    <= cfg_wr_data[DUTY_BITS-1:0];
                REG_DEAD_BAND:     cfg_reg.dead_band     <= cfg_wr_data[BAND_BITS-1:0];
                REG_TARGET_MIN:    cfg_reg.target_min    <= cfg_wr_data[POS_BITS-1:0];
                REG_TARGET_MAX:    cfg_reg.target_max    <= cfg_wr_data[POS_BITS-1:0];
                REG_MOTION_ENABLE: cfg_reg.motion_enable <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // the pipeline moves whenever the result slot is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.action <= action_t'(s_tuser);
            item_reg.quad_a <= s_tdata[0];
            item_reg.quad_b <= s_tdata[1];
            item_reg.target <= s_tdata[33:2];
        end
        if (advance && in_valid_reg) begin
            out_reg <= result;
        end
    end

    ebbpa_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_valid_reg && advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.setpoint, out_reg.position, out_reg.pwm_duty,
                       out_reg.bridge_low, out_reg.bridge_high};

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
    import ebbpa_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_PCT     = 11;
    localparam int REPORT_CAP   = 40;
    localparam logic [CFG_ADDR_BITS-1:0] REG_UNUSED = 3'd7;

    logic                     aclk        = 1'b0;
    logic                     aresetn     = 1'b0;
    logic                     cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr    = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wr_data = '0;
    logic                     s_tvalid    = 1'b0;
    logic                     s_tready;
    logic [39:0]              s_tdata     = '0;   // quad_a, quad_b, target[31:0], pad
    logic [1:0]               s_tuser     = '0;   // action
    logic                     m_tvalid;
    logic                     m_tready    = 1'b0;
    logic [79:0]              m_tdata;            // bridge_high, bridge_low, pwm_duty[6:0],
                                                  // position[31:0], setpoint[31:0], pad

    // register copies
    logic [DUTY_BITS-1:0]       duty_reg;
    logic [BAND_BITS-1:0]       band_reg;
    logic signed [POS_BITS-1:0] goal_min;
    logic signed [POS_BITS-1:0] goal_max;
    logic                       motion_on;

    // axis state as the block should hold it
    logic [3:0]                 quad_hist;
    logic [POS_BITS-1:0]        count;
    logic signed [POS_BITS-1:0] goal;
    logic                       reversing;
    logic                       line_hi;
    logic                       line_lo;
    logic [DUTY_BITS-1:0]       duty_out;

    result_t due_results[$];
    bit      steady = 1'b0;
    bit      failed = 1'b0;
    int      mismatches = 0;
    int      stall_cycles = 0;
    int      walk_idx = 0;

    encoder_bang_bang_position_axis DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int quad_delta(logic [3:0] hist);
        case (hist)
            4'd1, 4'd7, 4'd8, 4'd14: return -1;
            4'd2, 4'd4, 4'd11, 4'd13: return 1;
            default: return 0;
        endcase
    endfunction

    // when the window is inverted, goals above max take max and all others take min
    function automatic void clamp_goal(longint g);
        if (g > longint'(goal_max)) begin
            goal = goal_max;
        end else if (g < longint'(goal_min)) begin
            goal = goal_min;
        end else begin
            goal = POS_BITS'(g);
        end
    endfunction

    function automatic result_t advance_axis(action_t act, logic qa, logic qb,
                                             logic [POS_BITS-1:0] tgt);
        longint  pos;
        longint  band;
        result_t r;
        case (act)
            ACT_ENC_SAMPLE: begin
                quad_hist = {quad_hist[1:0], qb, qa};
                count = count + POS_BITS'(quad_delta(quad_hist));
            end
            ACT_CTRL_TICK: begin
                if (motion_on) begin
                    pos  = longint'($signed(count));
                    band = longint'(band_reg);
                    if (longint'(goal) - band > pos) begin
                        if (reversing) begin
                            reversing = 1'b0;
                            line_hi = 1'b0;
                            line_lo = 1'b0;
                        end else begin
                            line_hi = 1'b0;
                            line_lo = 1'b1;
                            duty_out = (duty_reg > DUTY_MAX) ? DUTY_MAX : duty_reg;
                        end
                    end else if (longint'(goal) + band < pos) begin
                        if (!reversing) begin
                            reversing = 1'b1;
                            line_hi = 1'b0;
                            line_lo = 1'b0;
                        end else begin
                            line_hi = 1'b1;
                            line_lo = 1'b0;
                            duty_out = (duty_reg > DUTY_MAX) ? DUTY_MAX : duty_reg;
                        end
                    end else begin
                        line_hi = 1'b0;
                        line_lo = 1'b0;
                        duty_out = '0;
                    end
                end
            end
            ACT_MOVE_ABS: clamp_goal(longint'($signed(tgt)));
            default:      clamp_goal(longint'(goal) + longint'($signed(tgt)));
        endcase
        r.bridge_high = line_hi;
        r.bridge_low  = line_lo;
        r.pwm_duty    = duty_out;
        r.position    = count;
        r.setpoint    = goal;
        return r;
    endfunction

    task automatic send_request(action_t act, logic qa, logic qb, logic [POS_BITS-1:0] tgt);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {6'b0, tgt, qb, qa};
        do @(posedge aclk); while (!s_tready);
        due_results.push_back(advance_axis(act, qa, qb, tgt));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_DRIVE_DUTY:    duty_reg  = val[DUTY_BITS-1:0];
            REG_DEAD_BAND:     band_reg  = val[BAND_BITS-1:0];
            REG_TARGET_MIN:    goal_min  = val[POS_BITS-1:0];
            REG_TARGET_MAX:    goal_max  = val[POS_BITS-1:0];
            REG_MOTION_ENABLE: motion_on = val[0];
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            failed = 1'b1;
            if (mismatches < REPORT_CAP)
                $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    failed = 1'b1;
                    $display("%0t unexpected result expected none actual %0h",
                             $time, m_tdata);
                end else begin
                    want = due_results.pop_front();
                    check_field("bridge_high", want.bridge_high, m_tdata[0]);
                    check_field("bridge_low", want.bridge_low, m_tdata[1]);
                    check_field("pwm_duty", want.pwm_duty, m_tdata[8:2]);
                    check_field("position", want.position, m_tdata[40:9]);
                    check_field("setpoint", want.setpoint, m_tdata[72:41]);
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("encoder_bang_bang_position_axis: mismatch");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // every 4-bit history at least once, motion disabled so ticks change nothing
    task automatic test_quadrature_table();
        logic [0:16][1:0] walk;
        walk = {2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
                2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
        send_request(ACT_CTRL_TICK, 1'b1, 1'b1, $urandom);
        for (int i = 0; i < 17; i++)
            send_request(ACT_ENC_SAMPLE, walk[i][0], walk[i][1], $urandom);
    endtask

    task automatic test_goal_clamp();
        send_request(ACT_MOVE_ABS, 1'b0, 1'b1, 32'h7FFF_FFFF);
        send_request(ACT_MOVE_REL, 1'b1, 1'b0, 32'h0000_0001);
        send_request(ACT_MOVE_ABS, 1'b0, 1'b0, 32'h8000_0000);
        send_request(ACT_MOVE_REL, 1'b1, 1'b1, 32'hFFFF_FFFF);
        wait_drained();
        // inverted window
        write_reg(REG_TARGET_MIN, 32'd10);
        write_reg(REG_TARGET_MAX, 32'hFFFF_FFF6);
        write_reg(REG_UNUSED, $urandom);
        send_request(ACT_MOVE_ABS, 1'b0, 1'b0, 32'd100);
        send_request(ACT_MOVE_ABS, 1'b0, 1'b0, 32'hFFFF_FF9C);
        send_request(ACT_MOVE_REL, 1'b0, 1'b0, 32'd0);
        wait_drained();
    endtask

    task automatic test_bang_bang();
        write_reg(REG_DRIVE_DUTY, 32'd127);
        write_reg(REG_DEAD_BAND, 32'd5);
        write_reg(REG_TARGET_MIN, TARGET_MIN_RST);
        write_reg(REG_TARGET_MAX, TARGET_MAX_RST);
        write_reg(REG_MOTION_ENABLE, 32'd1);
        send_request(ACT_MOVE_ABS, 1'b0, 1'b0, count + 32'd50);
        send_request(ACT_CTRL_TICK, 1'b0, 1'b0, '0);
        send_request(ACT_MOVE_ABS, 1'b0, 1'b0, count - 32'd50);
        send_request(ACT_CTRL_TICK, 1'b0, 1'b0, '0);
        send_request(ACT_CTRL_TICK, 1'b0, 1'b0, '0);
        send_request(ACT_MOVE_ABS, 1'b0, 1'b0, count + 32'd50);
        send_request(ACT_CTRL_TICK, 1'b0, 1'b0, '0);
        send_request(ACT_MOVE_ABS, 1'b0, 1'b0, count);
        send_request(ACT_CTRL_TICK, 1'b0, 1'b0, '0);
        wait_drained();
        // error exactly at the band edge, then one past it
        write_reg(REG_DEAD_BAND, 32'hFFFF_FFFF);
        send_request(ACT_MOVE_ABS, 1'b0, 1'b0, count + 32'd65535);
        send_request(ACT_CTRL_TICK, 1'b0, 1'b0, '0);
        send_request(ACT_MOVE_REL, 1'b0, 1'b0, 32'd1);
        send_request(ACT_CTRL_TICK, 1'b0, 1'b0, '0);
        wait_drained();
    endtask

    task automatic test_random_traffic(int n, logic [31:0] duty, logic [31:0] band,
                                       logic [31:0] lo, logic [31:0] hi,
                                       logic [31:0] motion, bit no_idle);
        int          pick;
        logic        qa;
        logic        qb;
        logic [31:0] noise;
        write_reg(REG_DRIVE_DUTY, duty);
        write_reg(REG_DEAD_BAND, band);
        write_reg(REG_TARGET_MIN, lo);
        write_reg(REG_TARGET_MAX, hi);
        write_reg(REG_MOTION_ENABLE, motion);
        steady = no_idle;
        for (int i = 0; i < n; i++) begin
            pick  = $urandom_range(99);
            noise = $urandom;
            qa    = $urandom_range(1);
            qb    = $urandom_range(1);
            if (pick < 45) begin
                // clean quadrature walk, mostly in the direction being driven
                if ($urandom_range(99) < 80 && (line_lo || line_hi))
                    walk_idx += line_lo ? 1 : -1;
                else
                    walk_idx += $urandom_range(1) ? 1 : -1;
                send_request(ACT_ENC_SAMPLE, walk_idx[1], walk_idx[1] ^ walk_idx[0], noise);
            end else if (pick < 50) begin
                send_request(ACT_ENC_SAMPLE, qa, qb, noise);
            end else if (pick < 80) begin
                send_request(ACT_CTRL_TICK, qa, qb, noise);
            end else if (pick < 92) begin
                if ($urandom_range(99) < 85)
                    noise = count + 32'($urandom_range(400)) - 32'd200;
                send_request(ACT_MOVE_ABS, qa, qb, noise);
            end else begin
                if ($urandom_range(99) < 85)
                    noise = 32'($urandom_range(200)) - 32'd100;
                send_request(ACT_MOVE_REL, qa, qb, noise);
            end
        end
        wait_drained();
        steady = 1'b0;
    endtask

    initial begin
        duty_reg  = DRIVE_DUTY_RST;
        band_reg  = DEAD_BAND_RST;
        goal_min  = TARGET_MIN_RST;
        goal_max  = TARGET_MAX_RST;
        motion_on = 1'b0;
        quad_hist = '0;
        count     = '0;
        goal      = '0;
        reversing = 1'b0;
        line_hi   = 1'b0;
        line_lo   = 1'b0;
        duty_out  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_quadrature_table();
        test_goal_clamp();
        test_bang_bang();
        test_random_traffic(120, 32'd0, 32'd0, 32'hFFFF_FC18, 32'd1000, 32'd1, 1'b0);
        test_random_traffic(100, 32'd100, 32'd65535, TARGET_MIN_RST, TARGET_MAX_RST,
                            32'd1, 1'b1);
        test_random_traffic(80, ($urandom & 32'hFFFF_FF80) | 32'd127,
                            32'($urandom_range(1, 40)) | 32'hABCD_0000,
                            $urandom, $urandom, 32'hFFFF_FFFE, 1'b0);
        test_random_traffic(200, 32'($urandom_range(127)), 32'($urandom_range(64)),
                            32'hFFFF_FE0C, 32'd500, 32'hFFFF_FFFF, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (!failed && due_results.size() == 0) begin
            $display("encoder_bang_bang_position_axis: match");
        end else begin
            $display("encoder_bang_bang_position_axis: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ebbpa_pkg.sv
rtl/core/ebbpa_core.sv
rtl/core/encoder_bang_bang_position_axis.sv
sim/testbench.sv
